>>> rtl/tma_pkg.sv
package tma_pkg;

  // Field widths fixed by the item format.
  localparam int PRICE_W   = 32;
  localparam int SUM_W     = 39;
  localparam int LEN_W     = 8;
  localparam int CNT_W     = 8;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // One input beat.
  typedef struct packed {
    logic [PRICE_W-1:0] close_price;
    logic               restart;
  } tma_in_t;

  // One result beat.
  typedef struct packed {
    logic [PRICE_W-1:0] average;
    logic               average_valid;
  } tma_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_FINISH
  } tma_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic start;
    logic div_step;
    logic finish;
  } tma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } tma_sts_t;

endpackage

>>> rtl/tma_div.sv
module tma_div (
  input  logic                     clk,
  input  logic                     load,
  input  logic                     step,
  input  logic [tma_pkg::SUM_W-1:0] dividend,
  input  logic [tma_pkg::LEN_W-1:0] divisor,
  output logic [tma_pkg::SUM_W-1:0] quotient
);
  import tma_pkg::*;

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    fits    = trial >= {1'b0, divisor};
    quo_nxt = {quo_r[SUM_W-2:0], fits};
    if (fits) begin
      rem_nxt = LEN_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[LEN_W-1:0];
    end
  end

  // The quotient builds up in the dividend register, one bit per step cycle.
  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;

endmodule

>>> rtl/tma_ctrl.sv
module tma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tma_pkg::tma_sts_t sts,
  output tma_pkg::tma_cmd_t cmd,
  output logic              in_stall
);
  import tma_pkg::*;

  tma_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_START;
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/tma_dp.sv
module tma_dp #(
  parameter int MAX_WINDOW = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tma_pkg::tma_cmd_t         cmd,
  output tma_pkg::tma_sts_t         sts,
  input  tma_pkg::tma_in_t          in_data,
  input  logic                      cfg_we,
  input  logic [tma_pkg::LEN_W-1:0] cfg_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tma_pkg::tma_out_t         out_data
);
  import tma_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);

  logic [PRICE_W-1:0] ring [MAX_WINDOW];
  logic [PRICE_W-1:0] rd_data_r;
  logic [PRICE_W-1:0] price_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [PTR_W-1:0]   wp_r;
  logic [LEN_W-1:0]   wl_r;
  logic               valid_r;
  logic               out_valid_r;
  tma_out_t           out_data_r;

  logic [LEN_W-1:0]   len_eff;
  logic [31:0]        wp_ext;
  logic [31:0]        len_ext;
  logic [31:0]        old_ext;
  logic [PTR_W-1:0]   old_idx;
  logic [PTR_W-1:0]   wp_inc;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   quotient;

  // Effective window: zero counts as one, longer windows clip to the ring size.
  always_comb begin
    if (wl_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(wl_r) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wl_r;
    end
  end

  // Slot of the price that leaves the window, and the next write slot.
  always_comb begin
    wp_ext  = 32'(wp_r);
    len_ext = 32'(len_eff);
    if (wp_ext >= len_ext) begin
      old_ext = wp_ext - len_ext;
    end else begin
      old_ext = wp_ext + 32'(MAX_WINDOW) - len_ext;
    end
    old_idx = old_ext[PTR_W-1:0];
    wp_inc  = (wp_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
  end

  // Running sum after this beat: new price in, leaving one out if window full.
  always_comb begin
    sum_nxt = sum_r + SUM_W'(price_r);
    if (valid_r) begin
      sum_nxt = sum_nxt - SUM_W'(rd_data_r);
    end
  end

  // Price ring; the leaving entry is read when the beat is taken, well
  // before the new price is written back.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ring[wp_r] <= price_r;
    end
    if (cmd.load_item) begin
      rd_data_r <= ring[old_idx];
    end
  end

  // Beat payload and window flag.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      price_r <= in_data.close_price;
    end
    if (cmd.start) begin
      valid_r <= count_r >= len_eff;
    end
  end

  // Window state: register, sum, count and write slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r    <= LEN_RESET;
      sum_r   <= '0;
      count_r <= '0;
      wp_r    <= '0;
    end else if (cfg_we) begin
      wl_r    <= cfg_data;
      sum_r   <= '0;
      count_r <= '0;
    end else if (cmd.load_item) begin
      if (in_data.restart) begin
        sum_r   <= '0;
        count_r <= '0;
      end
    end else if (cmd.finish) begin
      sum_r <= sum_nxt;
      wp_r  <= wp_inc;
      if (count_r != CNT_MAX) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Serial divider for the mean.
  tma_div u_div (
    .clk      (clk),
    .load     (cmd.start),
    .step     (cmd.div_step),
    .dividend (sum_r),
    .divisor  (len_eff),
    .quotient (quotient)
  );

  // Output register: holds a result until the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.average       <= valid_r ? quotient[PRICE_W-1:0] : '0;
      out_data_r.average_valid <= valid_r;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

>>> rtl/trailing_moving_average_top.sv
// Trailing simple moving average over a stream of unsigned Q16.16 prices.
// Each input beat yields one result beat: the truncated mean of the
// window_length prices that came before it, flagged invalid until that many
// prices of the current series have been seen. Setting restart on a beat, or
// writing window_length, starts a new series. One beat at a time is worked
// on, in order: the leaving price is read from the ring as the beat is taken,
// the divider is started, the bit-serial divider works through the 39-bit sum,
// and the result is written back once the output register is free; the next
// beat can be taken the cycle after that. A result waits in an output register,
// so a stall on the result side only holds the block once a second result is
// ready.
module trailing_moving_average_top #(
  parameter int MAX_WINDOW = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tma_pkg::tma_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tma_pkg::tma_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [tma_pkg::LEN_W-1:0] cfg_data
);
  import tma_pkg::*;

  tma_cmd_t cmd;
  tma_sts_t sts;

  // Sequencer.
  tma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Ring, running sum, divider and output register.
  tma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
